FILE: design/refcounted_page_frame_allocator_core_defines.svh
// Assertion macros shared by the page frame allocator modules.
// Expects signals named clock and reset in the module that uses them.
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// checked outside reset only
`define RPFA_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rpfa assertion failed");

// checked on every edge, reset included
`define RPFA_ASSERT_NORST(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("rpfa assertion failed");

`endif

FILE: design/rpfa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// reference counted page frame allocator. No dependencies.
`default_nettype none

package rpfa_pkg;

   localparam int MAX_PAGES = 4096;
   localparam int PAGE_W    = 12;
   localparam int CFG_W     = 13;
   localparam int REF_W     = 8;
   localparam int MODE_W    = 2;
   localparam int STAT_W    = 3;
   localparam int CSR_IDX_W = 1;

   // used-page bitmap is stored as rows of 64 pages
   localparam int ROW_W     = 64;
   localparam int ROW_SEL_W = 6;
   localparam int ROWS      = MAX_PAGES / ROW_W;
   localparam int ROW_IDX_W = PAGE_W - ROW_SEL_W;
   localparam int ROW_PTR_W = CFG_W - ROW_SEL_W;

   localparam logic [CFG_W-1:0] PAGE_LIMIT = CFG_W'(MAX_PAGES);
   localparam logic [CFG_W-1:0] FREE_MAX   = {CFG_W{1'b1}};
   localparam logic [REF_W-1:0] REF_LIMIT  = 8'd255;

   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SHARE   = 2'd2;

   localparam logic [STAT_W-1:0] STS_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STS_OOM     = 3'd1;
   localparam logic [STAT_W-1:0] STS_RANGE   = 3'd2;
   localparam logic [STAT_W-1:0] STS_UNALLOC = 3'd3;
   localparam logic [STAT_W-1:0] STS_SAT     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PAGE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT = 1'd1;

   // what the datapath commits at the end of a request
   localparam logic [1:0] CM_NONE  = 2'd0;
   localparam logic [1:0] CM_ALLOC = 2'd1;
   localparam logic [1:0] CM_OOM   = 2'd2;
   localparam logic [1:0] CM_PAGE  = 2'd3;

   typedef struct packed {
      logic       clr_en;
      logic       load_req;
      logic       scan_start;
      logic       scan_step;
      logic [1:0] commit;
      logic       out_load;
   } rpfa_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_alloc;
      logic start_oom;
      logic scan_hit;
      logic scan_end;
      logic out_free;
   } rpfa_stat_type;

endpackage

`default_nettype wire

FILE: design/refcounted_page_frame_allocator_core.sv
// Top level of the reference counted page frame allocator.
// Joins rpfa_ctrl (sequencer) and rpfa_dp (datapath); uses rpfa_pkg.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    req_mode, req_page_number
//   rsp_      out        rsp_valid/rsp_ready    rsp_result_page, rsp_ref_count,
//                                               rsp_free_count, rsp_status
//   csr_      in         csr_wr_en              csr_index, csr_wdata
//
// Release, share and the unused mode: dispatch, page update, done; rsp_valid then rises
// once the output register is free. Allocate: dispatch, a scan of the 64-page bitmap rows
// from first_usable_page upward (at most 64, none if no page is usable), one row per cycle.
// After reset a sweep clears all 64 bitmap rows; req_ready stays low meanwhile.
// One request at a time; the next is accepted while the previous result waits on rsp_.
`default_nettype none

module refcounted_page_frame_allocator_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rpfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rpfa_pkg::CFG_W-1:0]       csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rpfa_pkg::MODE_W-1:0]      req_mode,
   input  logic [rpfa_pkg::PAGE_W-1:0]      req_page_number,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rpfa_pkg::PAGE_W-1:0]      rsp_result_page,
   output logic [rpfa_pkg::REF_W-1:0]       rsp_ref_count,
   output logic [rpfa_pkg::CFG_W-1:0]       rsp_free_count,
   output logic [rpfa_pkg::STAT_W-1:0]      rsp_status
);

   rpfa_pkg::rpfa_cmd_type  cmd;
   rpfa_pkg::rpfa_stat_type stat;

   rpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rpfa_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_mode        (req_mode),
      .req_page_number (req_page_number),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_result_page (rsp_result_page),
      .rsp_ref_count   (rsp_ref_count),
      .rsp_free_count  (rsp_free_count),
      .rsp_status      (rsp_status),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

`default_nettype wire

FILE: design/rpfa_ctrl.sv
// Request sequencer for the page frame allocator: clear sweep, dispatch,
// allocation scan, page update and result hand-off. Uses rpfa_pkg and the defines header.
`default_nettype none
`include "refcounted_page_frame_allocator_core_defines.svh"

module rpfa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rpfa_pkg::rpfa_stat_type stat,
   output rpfa_pkg::rpfa_cmd_type  cmd
);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_DISPATCH = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_PAGE_EX  = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.is_alloc) begin
               if (stat.start_oom) begin
                  cmd.commit = rpfa_pkg::CM_OOM;
                  state_in   = S_DONE;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end else begin
               // bitmap row and count are being read this cycle
               state_in = S_PAGE_EX;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit) begin
               cmd.commit = rpfa_pkg::CM_ALLOC;
               state_in   = S_DONE;
            end else if (stat.scan_end) begin
               cmd.commit = rpfa_pkg::CM_OOM;
               state_in   = S_DONE;
            end
         end
         S_PAGE_EX: begin
            cmd.commit = rpfa_pkg::CM_PAGE;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `RPFA_ASSERT_NORST(a_reset_clears, reset |=> state_ff == S_CLEAR)
   `RPFA_ASSERT(a_commit_then_done, cmd.commit != rpfa_pkg::CM_NONE |=> state_ff == S_DONE)
   `RPFA_ASSERT(a_accept_dispatch, req_valid && req_ready |=> state_ff == S_DISPATCH)

endmodule

`default_nettype wire

FILE: design/rpfa_dp.sv
// Datapath of the page frame allocator: config registers, free counter,
// used-page bitmap and count memories, scan window logic, result registers.
// Uses rpfa_pkg and the defines header.
`default_nettype none
`include "refcounted_page_frame_allocator_core_defines.svh"

module rpfa_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rpfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rpfa_pkg::CFG_W-1:0]          csr_wdata,
   input  logic [rpfa_pkg::MODE_W-1:0]         req_mode,
   input  logic [rpfa_pkg::PAGE_W-1:0]         req_page_number,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [rpfa_pkg::PAGE_W-1:0]         rsp_result_page,
   output logic [rpfa_pkg::REF_W-1:0]          rsp_ref_count,
   output logic [rpfa_pkg::CFG_W-1:0]          rsp_free_count,
   output logic [rpfa_pkg::STAT_W-1:0]         rsp_status,
   input  rpfa_pkg::rpfa_cmd_type              cmd,
   output rpfa_pkg::rpfa_stat_type             stat
);

   function automatic logic [rpfa_pkg::CFG_W-1:0] usable_limit(
      input logic [rpfa_pkg::CFG_W-1:0] pcount);
      return (pcount < rpfa_pkg::PAGE_LIMIT) ? pcount : rpfa_pkg::PAGE_LIMIT;
   endfunction

   function automatic logic [rpfa_pkg::CFG_W-1:0] reload_free(
      input logic [rpfa_pkg::CFG_W-1:0] first,
      input logic [rpfa_pkg::CFG_W-1:0] pcount);
      logic [rpfa_pkg::CFG_W-1:0] lim;
      lim = usable_limit(pcount);
      return (lim > first) ? lim - first : '0;
   endfunction

   function automatic logic [rpfa_pkg::ROW_SEL_W-1:0] lowest_set(
      input logic [rpfa_pkg::ROW_W-1:0] v);
      logic [rpfa_pkg::ROW_SEL_W-1:0] idx;
      idx = '0;
      for (int i = rpfa_pkg::ROW_W - 1; i >= 0; i--) begin
         if (v[i]) idx = (rpfa_pkg::ROW_SEL_W)'(i);
      end
      return idx;
   endfunction

   // configuration and free counter
   logic [rpfa_pkg::CFG_W-1:0] first_ff, first_in;
   logic [rpfa_pkg::CFG_W-1:0] pcount_ff, pcount_in;
   logic [rpfa_pkg::CFG_W-1:0] free_ff, free_in;
   logic [rpfa_pkg::CFG_W-1:0] lim;

   // latched request
   logic [rpfa_pkg::MODE_W-1:0] mode_ff;
   logic [rpfa_pkg::PAGE_W-1:0] page_ff;

   // clear sweep and scan pointers
   logic [rpfa_pkg::ROW_IDX_W-1:0] clr_row_ff;
   logic [rpfa_pkg::ROW_PTR_W-1:0] scan_row_ff;
   logic [rpfa_pkg::ROW_IDX_W-1:0] chk_row_ff;
   logic                           chk_vld_ff;

   // memories
   logic [rpfa_pkg::ROW_W-1:0] used_mem [rpfa_pkg::ROWS];
   logic [rpfa_pkg::ROW_W-1:0] used_rd_ff;
   logic [rpfa_pkg::REF_W-1:0] ref_mem [rpfa_pkg::MAX_PAGES];
   logic [rpfa_pkg::REF_W-1:0] ref_rd_ff;

   logic                           used_we;
   logic [rpfa_pkg::ROW_IDX_W-1:0] used_waddr;
   logic [rpfa_pkg::ROW_W-1:0]     used_wdata;
   logic [rpfa_pkg::ROW_IDX_W-1:0] used_raddr;
   logic                           ref_we;
   logic [rpfa_pkg::PAGE_W-1:0]    ref_waddr;
   logic [rpfa_pkg::REF_W-1:0]     ref_wdata;

   // result hold and output registers
   logic [rpfa_pkg::PAGE_W-1:0] res_page_ff, res_page_in;
   logic [rpfa_pkg::REF_W-1:0]  res_count_ff, res_count_in;
   logic [rpfa_pkg::STAT_W-1:0] res_status_ff, res_status_in;
   logic                        rsp_valid_ff;
   logic [rpfa_pkg::PAGE_W-1:0] rsp_page_ff;
   logic [rpfa_pkg::REF_W-1:0]  rsp_count_ff;
   logic [rpfa_pkg::CFG_W-1:0]  rsp_free_ff;
   logic [rpfa_pkg::STAT_W-1:0] rsp_status_ff;

   // scan window
   logic [rpfa_pkg::ROW_PTR_W-1:0] row_ptr;
   logic [rpfa_pkg::ROW_W-1:0]     lo_mask, hi_mask, cand;
   logic [rpfa_pkg::ROW_SEL_W-1:0] hit_sel;
   logic [rpfa_pkg::PAGE_W-1:0]    hit_page;
   logic [rpfa_pkg::CFG_W-1:0]     hit_ext;

   // single page operations
   logic [rpfa_pkg::CFG_W-1:0] page_ext;
   logic                       in_range;
   logic [rpfa_pkg::ROW_W-1:0] pg_bit;
   logic                       pg_used;
   logic [rpfa_pkg::REF_W-1:0] cur_cnt;

   assign lim = usable_limit(pcount_ff);

   always_comb begin
      first_in  = first_ff;
      pcount_in = pcount_ff;
      unique case (csr_index)
         rpfa_pkg::CSR_FIRST_PAGE: first_in  = csr_wdata;
         rpfa_pkg::CSR_PAGE_COUNT: pcount_in = csr_wdata;
         default: ;
      endcase
   end

   // window of usable pages within the row under check
   assign row_ptr = {1'b0, chk_row_ff};

   always_comb begin
      if (first_ff[rpfa_pkg::CFG_W-1:rpfa_pkg::ROW_SEL_W] < row_ptr) begin
         lo_mask = '1;
      end else if (first_ff[rpfa_pkg::CFG_W-1:rpfa_pkg::ROW_SEL_W] == row_ptr) begin
         lo_mask = {rpfa_pkg::ROW_W{1'b1}} << first_ff[rpfa_pkg::ROW_SEL_W-1:0];
      end else begin
         lo_mask = '0;
      end
      if (lim[rpfa_pkg::CFG_W-1:rpfa_pkg::ROW_SEL_W] > row_ptr) begin
         hi_mask = '1;
      end else if (lim[rpfa_pkg::CFG_W-1:rpfa_pkg::ROW_SEL_W] == row_ptr) begin
         hi_mask = ~({rpfa_pkg::ROW_W{1'b1}} << lim[rpfa_pkg::ROW_SEL_W-1:0]);
      end else begin
         hi_mask = '0;
      end
   end

   assign cand     = ~used_rd_ff & lo_mask & hi_mask;
   assign hit_sel  = lowest_set(cand);
   assign hit_page = {chk_row_ff, hit_sel};
   assign hit_ext  = {1'b0, hit_page};

   assign page_ext = {1'b0, page_ff};
   assign in_range = (page_ext >= first_ff) && (page_ext < lim);
   assign pg_bit   = (rpfa_pkg::ROW_W)'(1) << page_ff[rpfa_pkg::ROW_SEL_W-1:0];
   assign pg_used  = |(used_rd_ff & pg_bit);
   // a page whose bitmap bit is clear has count zero, whatever the count memory holds
   assign cur_cnt  = pg_used ? ref_rd_ff : '0;

   assign stat.clr_last  = (clr_row_ff == (rpfa_pkg::ROW_IDX_W)'(rpfa_pkg::ROWS - 1));
   assign stat.is_alloc  = (mode_ff == rpfa_pkg::MODE_ALLOC);
   assign stat.start_oom = (first_ff >= lim);
   assign stat.scan_hit  = chk_vld_ff && (|cand);
   // the top row ends the scan even when the limit lies past it
   assign stat.scan_end  = chk_vld_ff && !(|cand)
                           && (!hi_mask[rpfa_pkg::ROW_W-1]
                               || chk_row_ff == (rpfa_pkg::ROW_IDX_W)'(rpfa_pkg::ROWS - 1));
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign used_raddr = cmd.scan_step ? scan_row_ff[rpfa_pkg::ROW_IDX_W-1:0]
                                     : page_ff[rpfa_pkg::PAGE_W-1:rpfa_pkg::ROW_SEL_W];

   always_comb begin
      used_we       = cmd.clr_en;
      used_waddr    = clr_row_ff;
      used_wdata    = '0;
      ref_we        = 1'b0;
      ref_waddr     = page_ff;
      ref_wdata     = cur_cnt;
      free_in       = free_ff;
      res_page_in   = page_ff;
      res_count_in  = '0;
      res_status_in = rpfa_pkg::STS_OK;
      case (cmd.commit)
         rpfa_pkg::CM_ALLOC: begin
            used_we      = 1'b1;
            used_waddr   = chk_row_ff;
            used_wdata   = used_rd_ff | ((rpfa_pkg::ROW_W)'(1) << hit_sel);
            ref_we       = 1'b1;
            ref_waddr    = hit_page;
            ref_wdata    = (rpfa_pkg::REF_W)'(1);
            free_in      = (free_ff != '0) ? free_ff - (rpfa_pkg::CFG_W)'(1) : free_ff;
            res_page_in  = hit_page;
            res_count_in = (rpfa_pkg::REF_W)'(1);
         end
         rpfa_pkg::CM_OOM: begin
            res_page_in   = '0;
            res_status_in = rpfa_pkg::STS_OOM;
         end
         rpfa_pkg::CM_PAGE: begin
            if (mode_ff == rpfa_pkg::MODE_RELEASE || mode_ff == rpfa_pkg::MODE_SHARE) begin
               if (!in_range) begin
                  res_status_in = rpfa_pkg::STS_RANGE;
               end else if (!pg_used) begin
                  res_status_in = rpfa_pkg::STS_UNALLOC;
               end else if (mode_ff == rpfa_pkg::MODE_RELEASE) begin
                  ref_we       = 1'b1;
                  ref_wdata    = cur_cnt - (rpfa_pkg::REF_W)'(1);
                  res_count_in = cur_cnt - (rpfa_pkg::REF_W)'(1);
                  if (cur_cnt == (rpfa_pkg::REF_W)'(1)) begin
                     // last reference gone: page goes back to the free pool
                     used_we    = 1'b1;
                     used_waddr = page_ff[rpfa_pkg::PAGE_W-1:rpfa_pkg::ROW_SEL_W];
                     used_wdata = used_rd_ff & ~pg_bit;
                     free_in    = (free_ff != rpfa_pkg::FREE_MAX)
                                  ? free_ff + (rpfa_pkg::CFG_W)'(1) : free_ff;
                  end
               end else if (cur_cnt >= rpfa_pkg::REF_LIMIT - (rpfa_pkg::REF_W)'(1)) begin
                  res_status_in = rpfa_pkg::STS_SAT;
                  res_count_in  = cur_cnt;
               end else begin
                  ref_we       = 1'b1;
                  ref_wdata    = cur_cnt + (rpfa_pkg::REF_W)'(1);
                  res_count_in = cur_cnt + (rpfa_pkg::REF_W)'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (used_we) used_mem[used_waddr] <= used_wdata;
      used_rd_ff <= used_mem[used_raddr];
   end

   always_ff @(posedge clock) begin
      if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
      ref_rd_ff <= ref_mem[page_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= '0;
         pcount_ff    <= rpfa_pkg::PAGE_LIMIT;
         free_ff      <= reload_free('0, rpfa_pkg::PAGE_LIMIT);
         clr_row_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            first_ff  <= first_in;
            pcount_ff <= pcount_in;
            free_ff   <= reload_free(first_in, pcount_in);
         end else if (cmd.commit != rpfa_pkg::CM_NONE) begin
            free_ff <= free_in;
         end
         if (cmd.clr_en) clr_row_ff <= clr_row_ff + (rpfa_pkg::ROW_IDX_W)'(1);
         if (cmd.scan_start) begin
            chk_vld_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            chk_vld_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_mode;
         page_ff <= req_page_number;
      end
      if (cmd.scan_start) begin
         scan_row_ff <= first_ff[rpfa_pkg::CFG_W-1:rpfa_pkg::ROW_SEL_W];
      end else if (cmd.scan_step) begin
         scan_row_ff <= scan_row_ff + (rpfa_pkg::ROW_PTR_W)'(1);
         chk_row_ff  <= scan_row_ff[rpfa_pkg::ROW_IDX_W-1:0];
      end
      if (cmd.commit != rpfa_pkg::CM_NONE) begin
         res_page_ff   <= res_page_in;
         res_count_ff  <= res_count_in;
         res_status_ff <= res_status_in;
      end
      if (cmd.out_load) begin
         rsp_page_ff   <= res_page_ff;
         rsp_count_ff  <= res_count_ff;
         rsp_free_ff   <= free_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_page = rsp_page_ff;
   assign rsp_ref_count   = rsp_count_ff;
   assign rsp_free_count  = rsp_free_ff;
   assign rsp_status      = rsp_status_ff;

   `RPFA_ASSERT(a_alloc_in_window, cmd.commit == rpfa_pkg::CM_ALLOC |-> hit_ext >= first_ff && hit_ext < lim)
   `RPFA_ASSERT(a_out_load_free, cmd.out_load |-> !rsp_valid_ff || rsp_ready)
   `RPFA_ASSERT(a_rsp_hold, rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_page_ff) && $stable(rsp_status_ff))

endmodule

`default_nettype wire
